FILE: src/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes, status codes and shared control types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_GT  = 4'd4, CMD_LT  = 4'd5, CMD_GE  = 4'd6, CMD_LE  = 4'd7,
        CMD_NE  = 4'd8, CMD_EQ  = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
        CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_TO_INT = 4'd14, CMD_FROM_INT = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // how the back end finishes an item
    typedef enum logic [1:0] {
        K_DONE = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        neg;
        logic [31:0] result;
        logic        flag;
        t_status     status;
    } t_ctl;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

FILE: src/fpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels carrying ALU requests and results.
// ----------------------------------------------------------------------------
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               flag;
    logic        [1:0]  status;

    modport source (output valid, result, flag, status, input ready);
    modport sink   (input valid, result, flag, status, output ready);
endinterface

FILE: src/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Decode stage: add/sub, compare, min/max and conversion ops, multiplier, divider chain setup.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8,
    parameter int DW = 32 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [3:0]           i_cmd,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output fpa_pkg::t_ctl        o_ctl,
    output logic [63:0]          o_prod,
    output logic [DW-1:0]        o_dq,
    output logic [31:0]          o_rem,
    output logic [31:0]          o_div
);

    fpa_pkg::t_ctl r_ctl, n_ctl;
    logic [63:0]   r_prod;
    logic [DW-1:0] r_dq;
    logic [31:0]   r_rem, r_div;

    logic [31:0] ua, ub;
    logic [32:0] sum, dif, incv, decv;
    logic [63:0] fi;
    logic        lt, eq;

    always_comb begin
        ua   = i_a[31] ? 32'(-i_a) : i_a;
        ub   = i_b[31] ? 32'(-i_b) : i_b;
        sum  = {i_a[31], i_a} + {i_b[31], i_b};
        dif  = {i_a[31], i_a} - {i_b[31], i_b};
        incv = {i_a[31], i_a} + 33'd1;
        decv = {i_a[31], i_a} - 33'd1;
        fi   = {{32{i_a[31]}}, i_a} << FRAC_BITS;
        lt   = $signed(i_a) < $signed(i_b);
        eq   = i_a == i_b;

        n_ctl        = '0;
        n_ctl.valid  = i_valid;
        n_ctl.kind   = fpa_pkg::K_DONE;
        n_ctl.neg    = i_a[31] ^ i_b[31];
        n_ctl.status = fpa_pkg::ST_OK;
        unique case (fpa_pkg::t_cmd'(i_cmd))
            fpa_pkg::CMD_ADD, fpa_pkg::CMD_INC: begin
                if (i_cmd == fpa_pkg::CMD_ADD) begin
                    n_ctl.result = sum[31:0];
                    if (sum[32] != sum[31]) begin
                        n_ctl.result = sum[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
                        n_ctl.status = fpa_pkg::ST_SAT;
                    end
                end else begin
                    n_ctl.result = incv[31:0];
                    if (incv[32] != incv[31]) begin
                        n_ctl.result = fpa_pkg::SAT_MAX;
                        n_ctl.status = fpa_pkg::ST_SAT;
                    end
                end
            end
            fpa_pkg::CMD_SUB, fpa_pkg::CMD_DEC: begin
                if (i_cmd == fpa_pkg::CMD_SUB) begin
                    n_ctl.result = dif[31:0];
                    if (dif[32] != dif[31]) begin
                        n_ctl.result = dif[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
                        n_ctl.status = fpa_pkg::ST_SAT;
                    end
                end else begin
                    n_ctl.result = decv[31:0];
                    if (decv[32] != decv[31]) begin
                        n_ctl.result = fpa_pkg::SAT_MIN;
                        n_ctl.status = fpa_pkg::ST_SAT;
                    end
                end
            end
            fpa_pkg::CMD_MUL: n_ctl.kind = fpa_pkg::K_MUL;
            fpa_pkg::CMD_DIV: begin
                if (ub == 32'd0) n_ctl.status = fpa_pkg::ST_DIV0;
                else             n_ctl.kind   = fpa_pkg::K_DIV;
            end
            fpa_pkg::CMD_GT:  n_ctl.flag = !lt && !eq;
            fpa_pkg::CMD_LT:  n_ctl.flag = lt;
            fpa_pkg::CMD_GE:  n_ctl.flag = !lt;
            fpa_pkg::CMD_LE:  n_ctl.flag = lt || eq;
            fpa_pkg::CMD_NE:  n_ctl.flag = !eq;
            fpa_pkg::CMD_EQ:  n_ctl.flag = eq;
            fpa_pkg::CMD_MIN: n_ctl.result = lt ? i_a : i_b;
            fpa_pkg::CMD_MAX: n_ctl.result = (lt || eq) ? i_b : i_a;
            fpa_pkg::CMD_TO_INT: n_ctl.result = 32'($signed(i_a) >>> FRAC_BITS);
            fpa_pkg::CMD_FROM_INT: begin
                n_ctl.result = fi[31:0];
                // overflow when the bits above the sign are not all sign copies
                if (fi[63:31] != {33{fi[63]}}) begin
                    n_ctl.result = fi[63] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
                    n_ctl.status = fpa_pkg::ST_SAT;
                end
            end
            default: n_ctl.result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= 64'(ua) * 64'(ub);
            r_dq         <= {ua, {FRAC_BITS{1'b0}}};
            r_rem        <= '0;
            r_div        <= ub;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;
    assign o_dq   = r_dq;
    assign o_rem  = r_rem;
    assign o_div  = r_div;

endmodule

FILE: src/fpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division step: takes one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module fpa_cell #(
    parameter int DW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fpa_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_prod,
    input  logic [DW-1:0] i_dq,
    input  logic [31:0]   i_rem,
    input  logic [31:0]   i_div,
    output fpa_pkg::t_ctl o_ctl,
    output logic [63:0]   o_prod,
    output logic [DW-1:0] o_dq,
    output logic [31:0]   o_rem,
    output logic [31:0]   o_div
);

    fpa_pkg::t_ctl r_ctl;
    logic [63:0]   r_prod;
    logic [DW-1:0] r_dq;
    logic [31:0]   r_rem, r_div;
    logic [32:0]   trial, diff;
    logic          ge;

    // dividend bits leave at the top of dq, quotient bits enter at the bottom
    always_comb begin
        trial = {i_rem, i_dq[DW-1]};
        ge    = trial >= {1'b0, i_div};
        diff  = trial - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= i_prod;
            r_dq         <= {i_dq[DW-2:0], ge};
            r_rem        <= ge ? diff[31:0] : trial[31:0];
            r_div        <= i_div;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;
    assign o_dq   = r_dq;
    assign o_rem  = r_rem;
    assign o_div  = r_div;

endmodule

FILE: src/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Rounding, sign and saturation for mul/div; output register.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = 8,
    parameter int DW = 32 + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fpa_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_prod,
    input  logic [DW-1:0] i_dq,
    input  logic [31:0]   i_rem,
    input  logic [31:0]   i_div,
    output logic          o_valid,
    output logic [31:0]   o_result,
    output logic          o_flag,
    output logic [1:0]    o_status
);

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    logic           r_valid;
    logic [31:0]    r_result, n_result;
    logic           r_flag;
    fpa_pkg::t_status r_status, n_status;
    logic [63:0]    mag, lim;
    logic           rnd;

    always_comb begin
        rnd = {i_rem, 1'b0} >= {1'b0, i_div};
        if (i_ctl.kind == fpa_pkg::K_MUL) mag = (i_prod + HALF) >> FRAC_BITS;
        else                              mag = 64'(i_dq) + 64'(rnd);
        lim = i_ctl.neg ? 64'h8000_0000 : 64'h7fff_ffff;

        n_result = i_ctl.result;
        n_status = i_ctl.status;
        if (i_ctl.kind != fpa_pkg::K_DONE) begin
            if (mag > lim) begin
                n_result = i_ctl.neg ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
                n_status = fpa_pkg::ST_SAT;
            end else begin
                n_result = i_ctl.neg ? 32'(-mag[31:0]) : mag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
            r_flag   <= i_ctl.flag;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_flag   = r_flag;
    assign o_status = r_status;

endmodule

FILE: src/fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU, 32-bit raw values with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries cmd, operand_a, operand_b; o_out returns result, flag and
//   status (0 ok, 1 saturated, 2 divide by zero), one result per item.
//   Every item, whatever its opcode, runs through the same pipeline:
//   a decode stage (add/sub, compare, min/max, conversions, 32x32 multiply), a chain of
//   32+FRAC_BITS divider cells producing one quotient bit each, and an
//   output stage that rounds and saturates. With the default FRAC_BITS of 8
//   values are Q24.8. One item per cycle is accepted while the output is not
//   stalled; results leave in order.
//   A stalled receiver freezes the whole pipeline: i_in.ready drops while
//   the output register holds an item that o_out.ready has not taken.
//   Reset clears all valid bits; nothing is in flight afterwards.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);

    localparam int DW = 32 + FRAC_BITS;

    logic en;
    fpa_pkg::t_ctl ctl  [0:DW];
    logic [63:0]   prod [0:DW];
    logic [DW-1:0] dq   [0:DW];
    logic [31:0]   rem  [0:DW];
    logic [31:0]   dvs  [0:DW];

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in.valid),
        .i_cmd(i_in.cmd), .i_a(i_in.operand_a), .i_b(i_in.operand_b),
        .o_ctl(ctl[0]), .o_prod(prod[0]), .o_dq(dq[0]), .o_rem(rem[0]),
        .o_div(dvs[0])
    );

    for (genvar g = 0; g < DW; g++) begin : g_cell
        fpa_cell #(.DW(DW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(ctl[g]), .i_prod(prod[g]), .i_dq(dq[g]), .i_rem(rem[g]),
            .i_div(dvs[g]),
            .o_ctl(ctl[g+1]), .o_prod(prod[g+1]), .o_dq(dq[g+1]),
            .o_rem(rem[g+1]), .o_div(dvs[g+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_ctl(ctl[DW]), .i_prod(prod[DW]), .i_dq(dq[DW]), .i_rem(rem[DW]),
        .i_div(dvs[DW]),
        .o_valid(o_out.valid), .o_result(o_out.result), .o_flag(o_out.flag),
        .o_status(o_out.status)
    );

endmodule

FILE: sim/fixed_point_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb
// Drives random and corner-case operations into the fixed-point ALU with
// random idling on both channels, and checks every result against an
// integer predictor of the ALU (Q24.8, rounding and saturation included).
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;

    localparam int FRAC = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        fpa_pkg::t_cmd      cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_op;

    typedef struct {
        logic [31:0]      result;
        logic             flag;
        fpa_pkg::t_status status;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpa_in_if  in_ch ();
    fpa_out_if out_ch ();

    fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_op  pending_ops[$];
    t_res expected_res[$];
    int   errors = 0;
    int   idle_cnt = 0;
    int   n_sat = 0;
    int   n_div0 = 0;
    bit   driving_done = 0;
    bit   in_taken = 0;
    int   cyc = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v, inout fpa_pkg::t_status st);
        if (v > 64'sd2147483647) begin
            st = fpa_pkg::ST_SAT;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            st = fpa_pkg::ST_SAT;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_res alu_predict(t_op op);
        t_res        r;
        longint      a, b, v;
        bit          neg;
        logic [63:0] ua, ub, q, rm;
        a = op.a;
        b = op.b;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r.result = '0;
        r.flag = 1'b0;
        r.status = fpa_pkg::ST_OK;
        v = 0;
        case (op.cmd)
            fpa_pkg::CMD_ADD: v = sat32(a + b, r.status);
            fpa_pkg::CMD_SUB: v = sat32(a - b, r.status);
            fpa_pkg::CMD_MUL: begin
                q = (ua * ub + (64'd1 << (FRAC - 1))) >> FRAC;
                v = sat32(neg ? -longint'(q) : longint'(q), r.status);
            end
            fpa_pkg::CMD_DIV: begin
                if (ub == 0) begin
                    r.status = fpa_pkg::ST_DIV0;
                end else begin
                    q = (ua << FRAC) / ub;
                    rm = (ua << FRAC) % ub;
                    if (rm >= ub - rm) q++;
                    v = sat32(neg ? -longint'(q) : longint'(q), r.status);
                end
            end
            fpa_pkg::CMD_GT: r.flag = a > b;
            fpa_pkg::CMD_LT: r.flag = a < b;
            fpa_pkg::CMD_GE: r.flag = a >= b;
            fpa_pkg::CMD_LE: r.flag = a <= b;
            fpa_pkg::CMD_NE: r.flag = a != b;
            fpa_pkg::CMD_EQ: r.flag = a == b;
            fpa_pkg::CMD_MIN: v = (a < b) ? a : b;
            fpa_pkg::CMD_MAX: v = (a > b) ? a : b;
            fpa_pkg::CMD_INC: v = sat32(a + 1, r.status);
            fpa_pkg::CMD_DEC: v = sat32(a - 1, r.status);
            fpa_pkg::CMD_TO_INT: v = a >>> FRAC;
            default: v = sat32(a * (64'sd1 <<< FRAC), r.status);
        endcase
        r.result = v[31:0];
        return r;
    endfunction

    // operand mix: edges, small values, full random
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3, 4: return 32'($signed($urandom_range(0, 8191)) - 4096);
            5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op make_op(fpa_pkg::t_cmd c, logic [31:0] a, logic [31:0] b);
        t_op op;
        op.cmd = c;
        op.a = a;
        op.b = b;
        return op;
    endfunction

    initial begin
        t_op op;
        for (int c = 0; c < 16; c++)
            pending_ops.push_back(make_op(fpa_pkg::t_cmd'(c), 32'h7fff_ffff,
                                          32'h8000_0000));
        pending_ops.push_back(make_op(fpa_pkg::CMD_DIV, 32'd1000, 32'd0));
        pending_ops.push_back(make_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_ffff));
        pending_ops.push_back(make_op(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000));
        pending_ops.push_back(make_op(fpa_pkg::CMD_MUL, 32'd128, 32'd1));
        pending_ops.push_back(make_op(fpa_pkg::CMD_MUL, 32'hffff_ff80, 32'd1));
        pending_ops.push_back(make_op(fpa_pkg::CMD_DIV, 32'd1, 32'd512));
        pending_ops.push_back(make_op(fpa_pkg::CMD_TO_INT, 32'hffff_ffff, 32'd0));
        pending_ops.push_back(make_op(fpa_pkg::CMD_EQ, 32'd5, 32'd5));
        pending_ops.push_back(make_op(fpa_pkg::CMD_FROM_INT, 32'hff80_0000,
                                      32'hffff_ffff));
        for (int i = 0; i < 1450; i++) begin
            op.cmd = fpa_pkg::t_cmd'($urandom_range(0, 15));
            op.a = pick_operand();
            op.b = ($urandom_range(0, 3) == 0) ? op.a : pick_operand();
            pending_ops.push_back(op);
        end
    end

    // idling is suppressed for a long stretch in the middle of the run
    function automatic bit take_break();
        if (cyc > 1000 && cyc < 1600) return 0;
        return $urandom_range(0, 99) < 32;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            cyc <= cyc + 1;
            out_ch.ready <= !take_break();
            if (!in_ch.valid || in_taken) begin
                if (pending_ops.size() != 0 && !take_break()) begin
                    in_ch.valid <= 1'b1;
                    in_ch.cmd <= pending_ops[0].cmd;
                    in_ch.operand_a <= pending_ops[0].a;
                    in_ch.operand_b <= pending_ops[0].b;
                    void'(pending_ops.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                    if (pending_ops.size() == 0) driving_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_op  op;
        t_res want;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                op.cmd = fpa_pkg::t_cmd'(in_ch.cmd);
                op.a = in_ch.operand_a;
                op.b = in_ch.operand_b;
                want = alu_predict(op);
                if (want.status == fpa_pkg::ST_SAT) n_sat++;
                if (want.status == fpa_pkg::ST_DIV0) n_div0++;
                expected_res.push_back(want);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (expected_res.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    want = expected_res.pop_front();
                    if (out_ch.result !== want.result) begin
                        $error("result: expected %h, got %h", want.result, out_ch.result);
                        errors++;
                    end
                    if (out_ch.flag !== want.flag) begin
                        $error("flag: expected %b, got %b", want.flag, out_ch.flag);
                        errors++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               out_ch.status);
                        errors++;
                    end
                end
            end
            idle_cnt <= moved ? 0 : idle_cnt + 1;
        end
    end

    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (driving_done && expected_res.size() == 0);
                repeat (FRAC + 60) @(posedge i_clk);
            end
            begin
                wait (idle_cnt >= STALL_LIMIT);
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                errors++;
            end
        join_any
        $display("covered all 16 opcodes, %0d saturating and %0d divide-by-zero items",
                 n_sat, n_div0);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: files.f
src/fpa_pkg.sv
src/fpa_if.sv
src/fpa_front.sv
src/fpa_cell.sv
src/fpa_back.sv
src/fixed_point_alu.sv
sim/fixed_point_alu_tb.sv
